### hdl/bat_pkg.sv
`default_nettype none

package bat_pkg;

  // table size
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // field widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned HITS_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USED_W   = 5;
  localparam int unsigned ENTRY_W  = ADDR_W + HITS_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD   = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_DEL   = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_HIT   = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_RST   = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_QUERY = REQ_W'(4);
  localparam logic [REQ_W-1:0] REQ_CLEAR = REQ_W'(5);

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STS_EXISTS    = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] STS_FULL      = STATUS_W'(3);

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [HITS_W-1:0] hits;
  } entry_t;

endpackage

`default_nettype wire

### hdl/bat_ram.sv
`default_nettype none

module bat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/breakpoint_address_table.sv
// Breakpoint address table: holds up to TABLE_DEPTH breakpoint addresses, each with a
// 32-bit hit counter that wraps. A beat is taken at a rising edge where start is high
// and busy is low; exactly one result beat follows, shown for one cycle with done_o high,
// and the receiver cannot stall it. Clear-all and the unused request codes finish at once:
// the result shows in the next cycle and busy stays low, so these can come every cycle.
// Add, delete, hit, counter reset and query scan the whole entry RAM through its single
// registered read port, one entry per cycle, then update the table in S_EXEC: the
// result is registered on leaving S_EXEC and busy is low again from that same edge, so
// the next beat can be taken at the edge that takes the result; no new request is taken
// while a scan runs. Valid bits live in flip-flops cleared by reset, so no clearing pass
// is needed after reset.
`default_nettype none

module breakpoint_address_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bat_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [bat_pkg::ADDR_W-1:0]    bp_address_i,
  output logic                               done_o,
  output logic      [bat_pkg::STATUS_W-1:0]  status_o,
  output logic      [bat_pkg::HITS_W-1:0]    hit_count_o,
  output logic      [bat_pkg::USED_W-1:0]    used_entries_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  // sequencer state
  state_e state_q, state_d;

  // latched request
  logic [bat_pkg::REQ_W-1:0]  req_q, req_d;
  logic [bat_pkg::ADDR_W-1:0] addr_q, addr_d;

  // read issue side of the scan
  bat_pkg::idx_t rd_idx_q, rd_idx_d;
  logic          issue_done_q, issue_done_d;

  // compare side of the scan, registered behind the read
  logic          cmp_vld_q, cmp_vld_d;
  bat_pkg::idx_t cmp_idx_q, cmp_idx_d;
  logic          cmp_last_q, cmp_last_d;

  // scan results
  logic                       found_q, found_d;
  bat_pkg::idx_t              found_idx_q, found_idx_d;
  logic [bat_pkg::HITS_W-1:0] hits_q, hits_d;
  logic                       free_found_q, free_found_d;
  bat_pkg::idx_t              free_idx_q, free_idx_d;

  // table occupancy
  logic [bat_pkg::TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [bat_pkg::CNT_W-1:0]       total_q, total_d;

  // result registers
  logic                         done_q, done_d;
  logic [bat_pkg::STATUS_W-1:0] status_q, status_d;
  logic [bat_pkg::HITS_W-1:0]   hit_count_q, hit_count_d;
  logic [bat_pkg::USED_W-1:0]   used_q, used_d;

  // entry RAM ports
  logic                        ram_we;
  bat_pkg::idx_t               ram_waddr;
  bat_pkg::entry_t             ram_wentry;
  logic [bat_pkg::ENTRY_W-1:0] ram_rdata;
  bat_pkg::entry_t             rd_entry;

  // per-entry compare, the one shared unit of the scan
  logic cmp_hit;
  logic cmp_free;

  bat_ram #(
    .WIDTH (bat_pkg::ENTRY_W),
    .DEPTH (bat_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = bat_pkg::entry_t'(ram_rdata);

  // entry under compare matches the request, or is the lowest free slot candidate
  assign cmp_hit  = cmp_vld_q && valid_q[cmp_idx_q] && (rd_entry.addr == addr_q);
  assign cmp_free = cmp_vld_q && !valid_q[cmp_idx_q];

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign hit_count_o    = hit_count_q;
  assign used_entries_o = used_q;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    addr_d       = addr_q;
    rd_idx_d     = rd_idx_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    cmp_last_d   = cmp_last_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    hits_d       = hits_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    total_d      = total_q;
    done_d       = 1'b0;
    status_d     = status_q;
    hit_count_d  = hit_count_q;
    used_d       = used_q;
    ram_we       = 1'b0;
    ram_waddr    = free_idx_q;
    ram_wentry   = '{addr: addr_q, hits: '0};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_type_i;
          addr_d = bp_address_i;
          if (req_type_i == bat_pkg::REQ_CLEAR) begin
            // valid bits are flops, so clear-all finishes at once
            valid_d     = '0;
            total_d     = '0;
            done_d      = 1'b1;
            status_d    = bat_pkg::STS_OK;
            hit_count_d = '0;
            used_d      = '0;
          end else if (req_type_i > bat_pkg::REQ_CLEAR) begin
            // unused codes: no change, report current count
            done_d      = 1'b1;
            status_d    = bat_pkg::STS_OK;
            hit_count_d = '0;
            used_d      = bat_pkg::USED_W'(total_q);
          end else begin
            state_d      = S_SCAN;
            rd_idx_d     = '0;
            issue_done_d = 1'b0;
            found_d      = 1'b0;
            free_found_d = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // read side: one address per cycle
        cmp_vld_d  = !issue_done_q;
        cmp_idx_d  = rd_idx_q;
        cmp_last_d = (rd_idx_q == bat_pkg::IDX_W'(bat_pkg::TABLE_DEPTH - 1));
        if (!issue_done_q) begin
          if (rd_idx_q == bat_pkg::IDX_W'(bat_pkg::TABLE_DEPTH - 1)) begin
            issue_done_d = 1'b1;
          end else begin
            rd_idx_d = bat_pkg::IDX_W'(rd_idx_q + 1'b1);
          end
        end
        // compare side: keep the lowest match and the lowest free slot
        if (cmp_hit && !found_q) begin
          found_d     = 1'b1;
          found_idx_d = cmp_idx_q;
          hits_d      = rd_entry.hits;
        end
        if (cmp_free && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cmp_idx_q;
        end
        if (cmp_vld_q && cmp_last_q) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d     = S_IDLE;
        done_d      = 1'b1;
        status_d    = bat_pkg::STS_OK;
        hit_count_d = '0;
        case (req_q)
          bat_pkg::REQ_ADD: begin
            if (found_q) begin
              status_d    = bat_pkg::STS_EXISTS;
              hit_count_d = hits_q;
            end else if (!free_found_q) begin
              status_d = bat_pkg::STS_FULL;
            end else begin
              ram_we              = 1'b1;
              ram_waddr           = free_idx_q;
              ram_wentry          = '{addr: addr_q, hits: '0};
              valid_d[free_idx_q] = 1'b1;
              total_d             = bat_pkg::CNT_W'(total_q + 1'b1);
            end
          end
          bat_pkg::REQ_DEL: begin
            if (found_q) begin
              valid_d[found_idx_q] = 1'b0;
              total_d              = bat_pkg::CNT_W'(total_q - 1'b1);
            end else begin
              status_d = bat_pkg::STS_NOT_FOUND;
            end
          end
          bat_pkg::REQ_HIT: begin
            if (found_q) begin
              // counter wraps at the top
              ram_we      = 1'b1;
              ram_waddr   = found_idx_q;
              ram_wentry  = '{addr: addr_q, hits: bat_pkg::HITS_W'(hits_q + 1'b1)};
              hit_count_d = bat_pkg::HITS_W'(hits_q + 1'b1);
            end else begin
              status_d = bat_pkg::STS_NOT_FOUND;
            end
          end
          bat_pkg::REQ_RST: begin
            if (found_q) begin
              ram_we     = 1'b1;
              ram_waddr  = found_idx_q;
              ram_wentry = '{addr: addr_q, hits: '0};
            end else begin
              status_d = bat_pkg::STS_NOT_FOUND;
            end
          end
          bat_pkg::REQ_QUERY: begin
            if (found_q) begin
              hit_count_d = hits_q;
            end else begin
              status_d = bat_pkg::STS_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
        // count after the update, modulo the field width
        used_d = bat_pkg::USED_W'(total_d);
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      addr_q       <= '0;
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      cmp_last_q   <= 1'b0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      hits_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      valid_q      <= '0;
      total_q      <= '0;
      done_q       <= 1'b0;
      status_q     <= '0;
      hit_count_q  <= '0;
      used_q       <= '0;
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      addr_q       <= addr_d;
      rd_idx_q     <= rd_idx_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      cmp_last_q   <= cmp_last_d;
      found_q      <= found_d;
      found_idx_q  <= found_idx_d;
      hits_q       <= hits_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      valid_q      <= valid_d;
      total_q      <= total_d;
      done_q       <= done_d;
      status_q     <= status_d;
      hit_count_q  <= hit_count_d;
      used_q       <= used_d;
    end
  end

`ifndef ASSERT_OFF
  // occupancy counter tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == bat_pkg::CNT_W'($countones(valid_q)))
    else $error("entry count out of step with valid bits");

  // scanning requests hold the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i < bat_pkg::REQ_CLEAR) |=> busy)
    else $error("scan request did not raise busy");

  // full only when every slot is in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bat_pkg::STS_FULL) |->
      used_entries_o == bat_pkg::USED_W'(bat_pkg::TABLE_DEPTH))
    else $error("table full reported with free slots");

  // a missing address never reports a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == bat_pkg::STS_NOT_FOUND) |-> hit_count_o == '0)
    else $error("nonzero count on not found");
`endif

endmodule

`default_nettype wire
